// File: rtl/hlr_pkg.sv
// ----------------------------------------------------------------------------
// hlr_pkg
// Shared types and constants for the largest-rectangle histogram block.
// ----------------------------------------------------------------------------
package hlr_pkg;

  // Result area width and saturation value
  localparam int unsigned AREA_W   = 26;
  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  // Bus widths of the stream ports
  localparam int unsigned IN_HEIGHT_W = 16;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 32;

  // Control from the sequencer to the area unit
  typedef struct packed {
    logic mul_en;  // score the popped entry this cycle
    logic clear;   // drop the running maximum for the next histogram
  } area_ctl_t;

endpackage

// File: rtl/hlr_ram.sv
// ----------------------------------------------------------------------------
// hlr_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module hlr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/hlr_area_unit.sv
// ----------------------------------------------------------------------------
// hlr_area_unit
// Shared multiplier: scores one popped bar per request, saturates the area
// and keeps the running maximum of the current histogram.
// ----------------------------------------------------------------------------
module hlr_area_unit #(
  parameter int unsigned HW = 16,
  parameter int unsigned SW = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hlr_pkg::area_ctl_t         ctl,
  input  logic [HW-1:0]              height,
  input  logic [SW-1:0]              span,
  output logic                       busy,
  output logic [hlr_pkg::AREA_W-1:0] best
);

  localparam int unsigned PWD = HW + SW;
  localparam int unsigned XW  = (PWD > hlr_pkg::AREA_W) ? PWD : hlr_pkg::AREA_W;

  logic [PWD-1:0]              prod_r;
  logic                        prod_v_r;
  logic [hlr_pkg::AREA_W-1:0]  best_r;
  logic [XW-1:0]               prod_x;
  logic [hlr_pkg::AREA_W-1:0]  area_sat;

  // Saturate the registered product to the area width
  always_comb begin
    prod_x = XW'(prod_r);
    if (prod_x > XW'(hlr_pkg::AREA_MAX)) begin
      area_sat = hlr_pkg::AREA_MAX;
    end else begin
      area_sat = prod_x[hlr_pkg::AREA_W-1:0];
    end
  end

  // Product register
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= PWD'(height) * PWD'(span);
    end
  end

  // Pending flag and running maximum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      best_r   <= '0;
    end else begin
      prod_v_r <= ctl.mul_en;
      if (ctl.clear) begin
        best_r <= '0;
      end else if (prod_v_r && (area_sat > best_r)) begin
        best_r <= area_sat;
      end
    end
  end

  assign busy = prod_v_r;
  assign best = best_r;

endmodule

// File: rtl/histogram_largest_rectangle_top.sv
// ----------------------------------------------------------------------------
// histogram_largest_rectangle_top
// Largest rectangle under a streamed histogram, monotonic stack in a RAM.
// ----------------------------------------------------------------------------
// One bar is taken per input request; the request with tlast closes the
// histogram and yields one result: the largest area and an overflow flag set
// when more than MAX_BARS bars arrived (extra bars are ignored). The stack of
// (height, position) pairs lives in a single-port-read RAM whose read data is
// registered; the top entry is cached in flops. A bar is accepted in ST_IDLE
// and pushed in ST_POP; every entry it pops first passes ST_POP (RAM read of
// the new top), then ST_LOAD (the shared multiplier). The last bar also pops
// every entry left on the stack, then ST_OUT posts the result. The result
// waits in an output register; a new histogram may start while it is still
// held.
module histogram_largest_rectangle_top #(
  parameter int unsigned MAX_BARS    = 1024,
  parameter int unsigned HEIGHT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] height
  input  logic        in_tlast,   // last_bar
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [25:0] max_area, [31:26] zero
  output logic        out_tuser   // overflow
);

  localparam int unsigned HW   = (HEIGHT_BITS < hlr_pkg::IN_HEIGHT_W) ?
                                 HEIGHT_BITS : hlr_pkg::IN_HEIGHT_W;
  localparam int unsigned PW   = $clog2(MAX_BARS);
  localparam int unsigned CNTW = $clog2(MAX_BARS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_LOAD,
    ST_OUT
  } state_t;

  state_t          state_r, state_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [CNTW-1:0] bar_pos_r, bar_pos_nxt;
  logic [HW-1:0]   top_h_r, top_h_nxt;
  logic [HW-1:0]   pop_h_r, pop_h_nxt;
  logic [HW-1:0]   thr_r, thr_nxt;
  logic            last_r, last_nxt;
  logic            flush_r, flush_nxt;
  logic            ovf_r, ovf_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [hlr_pkg::AREA_W-1:0] out_area_r, out_area_nxt;
  logic            out_ovf_r, out_ovf_nxt;

  logic                 ram_wr_en;
  logic [PW-1:0]        ram_wr_addr;
  logic [HW+PW-1:0]     ram_wr_data;
  logic                 ram_rd_en;
  logic [PW-1:0]        ram_rd_addr;
  logic [HW+PW-1:0]     ram_rd_data;
  logic [HW-1:0]        rd_h;
  logic [PW-1:0]        rd_p;

  hlr_pkg::area_ctl_t   actl;
  logic [CNTW-1:0]      span;
  logic                 area_busy;
  logic [hlr_pkg::AREA_W-1:0] best_area;
  logic [CNTW-1:0]      below_idx;

  assign rd_h      = ram_rd_data[HW+PW-1:PW];
  assign rd_p      = ram_rd_data[PW-1:0];
  assign below_idx = count_r - CNTW'(2);

  // Stack storage
  hlr_ram #(
    .WIDTH (HW + PW),
    .DEPTH (MAX_BARS)
  ) u_stack (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Shared multiplier and running maximum
  hlr_area_unit #(
    .HW (HW),
    .SW (CNTW)
  ) u_area (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (actl),
    .height (pop_h_r),
    .span   (span),
    .busy   (area_busy),
    .best   (best_area)
  );

  assign in_tready = (state_r == ST_IDLE);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    bar_pos_nxt   = bar_pos_r;
    top_h_nxt     = top_h_r;
    pop_h_nxt     = pop_h_r;
    thr_nxt       = thr_r;
    last_nxt      = last_r;
    flush_nxt     = flush_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_area_nxt  = out_area_r;
    out_ovf_nxt   = out_ovf_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = count_r[PW-1:0];
    ram_wr_data   = {thr_r, bar_pos_r[PW-1:0]};
    ram_rd_en     = 1'b0;
    ram_rd_addr   = below_idx[PW-1:0];
    actl          = '0;
    span          = bar_pos_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          last_nxt = in_tlast;
          if (bar_pos_r >= CNTW'(MAX_BARS)) begin
            // Extra bar: ignored, flagged
            ovf_nxt = 1'b1;
            if (in_tlast) begin
              thr_nxt   = '0;
              flush_nxt = 1'b1;
              state_nxt = ST_POP;
            end
          end else begin
            thr_nxt   = in_tdata[HW-1:0];
            flush_nxt = 1'b0;
            state_nxt = ST_POP;
          end
        end
      end

      ST_POP: begin
        if ((count_r != '0) && (top_h_r > thr_r)) begin
          // Pop the top; fetch the entry below it
          pop_h_nxt = top_h_r;
          count_nxt = count_r - CNTW'(1);
          ram_rd_en = (count_r > CNTW'(1));
          state_nxt = ST_LOAD;
        end else if (!flush_r) begin
          // Push the new bar
          ram_wr_en   = 1'b1;
          top_h_nxt   = thr_r;
          count_nxt   = count_r + CNTW'(1);
          bar_pos_nxt = bar_pos_r + CNTW'(1);
          if (last_r) begin
            thr_nxt   = '0;
            flush_nxt = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_OUT;
        end
      end

      ST_LOAD: begin
        // New top arrives; score the popped bar
        actl.mul_en = 1'b1;
        if (count_r != '0) begin
          top_h_nxt = rd_h;
          span      = bar_pos_r - CNTW'(rd_p) - CNTW'(1);
        end
        state_nxt = ST_POP;
      end

      ST_OUT: begin
        if (!area_busy && (!out_valid_r || out_tready)) begin
          out_valid_nxt = 1'b1;
          out_area_nxt  = best_area;
          out_ovf_nxt   = ovf_r;
          actl.clear    = 1'b1;
          count_nxt     = '0;
          bar_pos_nxt   = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      bar_pos_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      bar_pos_r   <= bar_pos_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    top_h_r    <= top_h_nxt;
    pop_h_r    <= pop_h_nxt;
    thr_r      <= thr_nxt;
    last_r     <= last_nxt;
    flush_r    <= flush_nxt;
    out_area_r <= out_area_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = hlr_pkg::OUT_TDATA_W'(out_area_r);
  assign out_tuser  = out_ovf_r;

endmodule
